FILE: src/cbb_pkg.sv
// shared constants and register codes of the clipped box blur
`timescale 1ns / 1ps
package cbb_pkg;
  localparam int MAX_RADIUS = 5;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int LANES   = 3;
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 2;

  localparam logic [2:0]       RADIUS_RESET = 3'd5;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

  localparam logic [CFG_IW-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd2;
endpackage

FILE: src/cbb_if.sv
// pixel input and result output channel interfaces
`timescale 1ns / 1ps
interface cbb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [cbb_pkg::PIX_W-1:0]     red_in;
  logic [cbb_pkg::PIX_W-1:0]     green_in;
  logic [cbb_pkg::PIX_W-1:0]     blue_in;
  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface cbb_out_if;
  logic                          valid;
  logic                          ready;
  logic [cbb_pkg::PIX_W-1:0]     red_out;
  logic [cbb_pkg::PIX_W-1:0]     green_out;
  logic [cbb_pkg::PIX_W-1:0]     blue_out;
  logic                          frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

FILE: src/clipped_box_blur_rgb.sv
// top level: clipped box blur over an rgb raster stream
// an item that yields no result passes through the idle and decode states; a
// result item also reads the line store once per clipped window pixel, then
// runs the 8-step divider and waits for the output to be free
// a result leaves its input by radius*width+radius items
// reset is asynchronous active low; the line store holds no reset state
`timescale 1ns / 1ps
module clipped_box_blur_rgb #(
  parameter int MAX_RADIUS = cbb_pkg::MAX_RADIUS,
  parameter int MAX_WIDTH  = cbb_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = cbb_pkg::MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cbb_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [cbb_pkg::CFG_W-1:0]  cfg_data_i,
  cbb_in_if.sink                     in_i,
  cbb_out_if.source                  out_o
);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int NXW   = RW + 1;
  localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                + MAX_RADIUS + 1);
  localparam int DEPTH = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int NW    = $clog2(WIN * WIN + 1);
  localparam int SW    = $clog2(255 * WIN * WIN + 1);
  localparam int PW    = cbb_pkg::PIX_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_START  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_FLUSH  = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  // configuration
  logic [2:0]               radius_q;
  logic [cbb_pkg::CFG_W-1:0] width_q, height_q;
  logic [RW-1:0] r_c, r_q;
  logic [XW-1:0] w_c, w_q;
  logic [YW-1:0] h_c, h_q;
  logic [TW-1:0] npix_q, delay_q;

  always_comb begin
    if (32'(radius_q) > MAX_RADIUS) r_c = RW'(MAX_RADIUS);
    else r_c = RW'(radius_q);
    if (width_q == '0) w_c = XW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_c = XW'(MAX_WIDTH);
    else w_c = XW'(width_q);
    if (height_q == '0) h_c = YW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_c = YW'(MAX_HEIGHT);
    else h_c = YW'(height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cbb_pkg::RADIUS_RESET;
      width_q  <= cbb_pkg::WIDTH_RESET;
      height_q <= cbb_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbb_pkg::CFG_RADIUS: radius_q <= cfg_data_i[2:0];
        cbb_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        cbb_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_c;
    w_q     <= w_c;
    h_q     <= h_c;
    npix_q  <= TW'(w_c) * TW'(h_c);
    delay_q <= TW'(r_c) * TW'(w_c) + TW'(r_c);
  end

  logic cfg_restart;
  assign cfg_restart = cfg_we_i && (cfg_idx_i == cbb_pkg::CFG_RADIUS ||
                                    cfg_idx_i == cbb_pkg::CFG_WIDTH ||
                                    cfg_idx_i == cbb_pkg::CFG_HEIGHT);

  // control state
  logic [3:0]     state_q, state_d;
  logic [TW-1:0]  t_q;
  logic [AW-1:0]  tmod_q, base_q, rd_addr_q;
  logic [YW-1:0]  row_q;
  logic [XW-1:0]  col_q;
  logic [NXW-1:0] nx_q, ny_q, xi_q, yi_q;
  logic [NW-1:0]  cnt_q;
  logic [AW-1:0]  off_q;
  logic [XW-1:0]  rstep_q;
  logic           fend_q, rvalid_q;
  logic           act_q;
  logic [3*PW-1:0] pix_q;
  logic [SW-1:0]  acc_q [cbb_pkg::LANES];
  logic           out_valid_q, out_fend_q;
  logic [PW-1:0]  out_pix_q [cbb_pkg::LANES];
  logic [3*PW-1:0] rdata;

  // window geometry
  logic [RW-1:0]  up_v, dn_v, lf_v, rt_v;
  logic [YW-1:0]  below_v;
  logic [XW-1:0]  right_v;
  logic [NXW-1:0] nx_v, ny_v;
  always_comb begin
    below_v = h_q - YW'(1) - row_q;
    right_v = w_q - XW'(1) - col_q;
    up_v = (YW'(r_q) < row_q)   ? r_q : RW'(row_q);
    dn_v = (YW'(r_q) < below_v) ? r_q : RW'(below_v);
    lf_v = (XW'(r_q) < col_q)   ? r_q : RW'(col_q);
    rt_v = (XW'(r_q) < right_v) ? r_q : RW'(right_v);
    nx_v = NXW'(lf_v) + NXW'(rt_v);
    ny_v = NXW'(up_v) + NXW'(dn_v);
  end

  logic t_lt_npix, t_lt_delay, out_free, div_done;
  logic [PW-1:0] quot [cbb_pkg::LANES];
  assign t_lt_npix  = t_q < npix_q;
  assign t_lt_delay = t_q < delay_q;
  assign out_free   = !out_valid_q || out_o.ready;

  logic [AW:0] addr_sum, start_sum;
  always_comb begin
    if (xi_q == nx_q) addr_sum = (AW+1)'(rd_addr_q) + (AW+1)'(rstep_q);
    else addr_sum = (AW+1)'(rd_addr_q) + (AW+1)'(1);
    if (addr_sum >= (AW+1)'(DEPTH)) addr_sum = addr_sum - (AW+1)'(DEPTH);
    if (base_q >= off_q) start_sum = (AW+1)'(base_q) - (AW+1)'(off_q);
    else start_sum = (AW+1)'(base_q) + (AW+1)'(DEPTH) - (AW+1)'(off_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_DEC;
      S_DEC: begin
        if (t_lt_npix && act_q) state_d = S_IDLE;
        else if (t_lt_delay) state_d = S_IDLE;
        else state_d = S_SETUP;
      end
      S_SETUP:  state_d = S_START;
      S_START:  state_d = S_SCAN;
      S_SCAN:   if (xi_q == nx_q && yi_q == ny_q) state_d = S_FLUSH;
      S_FLUSH:  state_d = S_DSTART;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (div_done) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      t_q         <= '0;
      tmod_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= (state_q == S_SCAN);
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (cfg_restart) begin
        t_q    <= '0;
        tmod_q <= '0;
        row_q  <= '0;
        col_q  <= '0;
      end else if (state_q == S_DEC && !(t_lt_npix && act_q)) begin
        t_q    <= t_q + 1'b1;
        tmod_q <= (tmod_q == AW'(DEPTH - 1)) ? '0 : tmod_q + 1'b1;
      end else if (state_q == S_OUT && out_free) begin
        if (fend_q) begin
          t_q    <= '0;
          tmod_q <= '0;
          row_q  <= '0;
          col_q  <= '0;
        end else if (col_q == w_q - XW'(1)) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q <= in_i.action;
      pix_q <= {in_i.red_in, in_i.green_in, in_i.blue_in};
    end
    if (state_q == S_DEC) base_q <= tmod_q;
    if (state_q == S_SETUP) begin
      nx_q    <= nx_v;
      ny_q    <= ny_v;
      cnt_q   <= NW'(nx_v + 1'b1) * NW'(ny_v + 1'b1);
      off_q   <= AW'(NXW'(r_q) + NXW'(up_v)) * AW'(w_q) + AW'(r_q) + AW'(lf_v);
      rstep_q <= w_q - XW'(nx_v);
      fend_q  <= (row_q == h_q - YW'(1)) && (col_q == w_q - XW'(1));
      for (int i = 0; i < cbb_pkg::LANES; i++) acc_q[i] <= '0;
    end else if (rvalid_q) begin
      for (int i = 0; i < cbb_pkg::LANES; i++) begin
        acc_q[i] <= acc_q[i] + SW'(rdata[(cbb_pkg::LANES-1-i)*PW +: PW]);
      end
    end
    if (state_q == S_START) begin
      rd_addr_q <= AW'(start_sum);
      xi_q      <= '0;
      yi_q      <= '0;
    end else if (state_q == S_SCAN) begin
      rd_addr_q <= AW'(addr_sum);
      if (xi_q == nx_q) begin
        xi_q <= '0;
        yi_q <= yi_q + 1'b1;
      end else begin
        xi_q <= xi_q + 1'b1;
      end
    end
    if (state_q == S_OUT && out_free) begin
      out_pix_q  <= quot;
      out_fend_q <= fend_q;
    end
  end

  cbb_ram #(
    .WIDTH (3 * PW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (state_q == S_DEC && t_lt_npix && !act_q),
    .waddr_i (tmod_q),
    .wdata_i (pix_q),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  cbb_div #(
    .SW (SW),
    .NW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DSTART),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = out_pix_q[0];
  assign out_o.green_out = out_pix_q[1];
  assign out_o.blue_out  = out_pix_q[2];
  assign out_o.frame_end = out_fend_q;
endmodule

FILE: src/cbb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/cbb_div.sv
// three lane restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cbb_div #(
  parameter int SW = 15,
  parameter int NW = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SW-1:0]             dividend_i [cbb_pkg::LANES],
  input  logic [NW-1:0]             divisor_i,
  output logic [cbb_pkg::PIX_W-1:0] quot_o [cbb_pkg::LANES],
  output logic                      done_o
);
  localparam int QW  = cbb_pkg::PIX_W;
  localparam int DW  = NW + QW;
  localparam int STW = $clog2(QW);

  logic           busy_q, done_q;
  logic [STW-1:0] step_q;
  logic [DW-1:0]  rem_q [cbb_pkg::LANES];
  logic [DW-1:0]  dsr_q;
  logic [QW-1:0]  quot_q [cbb_pkg::LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STW'(QW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // mean fits in eight bits, so eight steps cover the quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= DW'(divisor_i) << (QW - 1);
      for (int i = 0; i < cbb_pkg::LANES; i++) begin
        rem_q[i]  <= DW'(dividend_i[i]);
        quot_q[i] <= '0;
      end
    end else if (busy_q) begin
      dsr_q <= dsr_q >> 1;
      for (int i = 0; i < cbb_pkg::LANES; i++) begin
        if (rem_q[i] >= dsr_q) begin
          rem_q[i]  <= rem_q[i] - dsr_q;
          quot_q[i] <= {quot_q[i][QW-2:0], 1'b1};
        end else begin
          quot_q[i] <= {quot_q[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;
endmodule
